// File: sv/dkfd_pkg.sv
// ----------------------------------------------------------------------------
// DER key format detector package
// Parse phases, format codes, DER tag constants and the per-byte result record.
// ----------------------------------------------------------------------------
package dkfd_pkg;

    localparam logic [7:0] TAG_SEQUENCE     = 8'h30;
    localparam logic [7:0] TAG_INTEGER      = 8'h02;
    localparam logic [7:0] TAG_BIT_STRING   = 8'h03;
    localparam logic [7:0] TAG_OCTET_STRING = 8'h04;
    localparam logic [7:0] LEN_LONG_FLAG    = 8'h80;
    localparam logic [6:0] LEN_COUNT_MASK   = 7'h7f;

    typedef enum logic [3:0] {
        PH_OUTER_TAG       = 4'd0,
        PH_OUTER_LEN       = 4'd1,
        PH_OUTER_LEN_BYTES = 4'd2,
        PH_INNER_TAG       = 4'd3,
        PH_INNER_LEN       = 4'd4,
        PH_INNER_LEN_BYTES = 4'd5,
        PH_INNER_VALUE     = 4'd6,
        PH_NEXT_TAG        = 4'd7
    } t_phase;

    typedef enum logic [1:0] {
        FMT_NONE      = 2'd0,
        FMT_PKCS8     = 2'd1,
        FMT_SPKI      = 2'd2,
        FMT_ENC_PKCS8 = 2'd3
    } t_format;

    typedef struct packed {
        logic    valid;
        t_format format;
    } t_result;

endpackage

// File: sv/dkfd_step.sv
// ----------------------------------------------------------------------------
// DER key format detector byte step
// Next parse state and optional result for one byte of the buffer.
// ----------------------------------------------------------------------------
module dkfd_step #(
    parameter int MAX_LENGTH_BYTES = 4,
    localparam int LW = $clog2(MAX_LENGTH_BYTES + 1),
    localparam int VW = 8 * MAX_LENGTH_BYTES
) (
    input  dkfd_pkg::t_phase  i_phase,
    input  logic [LW-1:0]     i_len_left,
    input  logic [VW-1:0]     i_value_left,
    input  logic              i_decided,
    input  logic [7:0]        i_data_byte,
    input  logic              i_end_of_buffer,
    output dkfd_pkg::t_phase  o_phase,
    output logic [LW-1:0]     o_len_left,
    output logic [VW-1:0]     o_value_left,
    output logic              o_decided,
    output dkfd_pkg::t_result o_result
);
    import dkfd_pkg::*;

    localparam logic [6:0] MaxLenCode = 7'(MAX_LENGTH_BYTES);

    t_phase        c_phase;
    logic [LW-1:0] c_len;
    logic [VW-1:0] c_value;
    logic          c_done;
    t_format       c_fmt;
    logic [6:0]    len_count;
    logic          long_ok;
    logic [VW-1:0] shifted;

    assign len_count = i_data_byte[6:0] & LEN_COUNT_MASK;
    assign long_ok   = (len_count != 7'd0) && (len_count <= MaxLenCode);
    assign shifted   = VW'({i_value_left, i_data_byte});

    always_comb begin
        c_phase = i_phase;
        c_len   = i_len_left;
        c_value = i_value_left;
        c_done  = 1'b0;
        c_fmt   = FMT_NONE;
        unique case (i_phase)
            PH_OUTER_TAG: begin
                if (i_data_byte != TAG_SEQUENCE) begin
                    c_done = 1'b1;
                end else begin
                    c_phase = PH_OUTER_LEN;
                end
            end
            PH_OUTER_LEN: begin
                if (i_data_byte < LEN_LONG_FLAG) begin
                    c_phase = PH_INNER_TAG;
                end else if (!long_ok) begin
                    c_done = 1'b1;
                end else begin
                    c_len   = len_count[LW-1:0];
                    c_phase = PH_OUTER_LEN_BYTES;
                end
            end
            PH_OUTER_LEN_BYTES: begin
                c_len = i_len_left - LW'(1);
                if (i_len_left == LW'(1)) begin
                    c_phase = PH_INNER_TAG;
                end
            end
            PH_INNER_TAG: begin
                if (i_data_byte == TAG_INTEGER) begin
                    c_done = 1'b1;
                    c_fmt  = FMT_PKCS8;
                end else if (i_data_byte != TAG_SEQUENCE) begin
                    c_done = 1'b1;
                end else begin
                    c_phase = PH_INNER_LEN;
                end
            end
            PH_INNER_LEN: begin
                if (i_data_byte < LEN_LONG_FLAG) begin
                    c_value = VW'(i_data_byte);
                    c_phase = (i_data_byte == 8'd0) ? PH_NEXT_TAG : PH_INNER_VALUE;
                end else if (!long_ok) begin
                    c_done = 1'b1;
                end else begin
                    c_len   = len_count[LW-1:0];
                    c_value = '0;
                    c_phase = PH_INNER_LEN_BYTES;
                end
            end
            PH_INNER_LEN_BYTES: begin
                c_value = shifted;
                c_len   = i_len_left - LW'(1);
                if (i_len_left == LW'(1)) begin
                    c_phase = (shifted == '0) ? PH_NEXT_TAG : PH_INNER_VALUE;
                end
            end
            PH_INNER_VALUE: begin
                c_value = i_value_left - VW'(1);
                if (i_value_left == VW'(1)) begin
                    c_phase = PH_NEXT_TAG;
                end
            end
            PH_NEXT_TAG: begin
                c_done = 1'b1;
                if (i_data_byte == TAG_BIT_STRING) begin
                    c_fmt = FMT_SPKI;
                end else if (i_data_byte == TAG_OCTET_STRING) begin
                    c_fmt = FMT_ENC_PKCS8;
                end
            end
            default: begin
                c_done = 1'b1;
            end
        endcase
    end

    // Once a buffer is decided, bytes are dropped until the flagged last byte,
    // which returns everything to the reset state.
    always_comb begin
        o_phase         = c_phase;
        o_len_left      = c_len;
        o_value_left    = c_value;
        o_decided       = i_decided;
        o_result.valid  = 1'b0;
        o_result.format = c_fmt;
        if (!i_decided) begin
            o_result.valid = c_done || i_end_of_buffer;
            o_decided      = c_done;
        end
        if (i_decided && !i_end_of_buffer) begin
            o_phase      = i_phase;
            o_len_left   = i_len_left;
            o_value_left = i_value_left;
        end
        if (i_end_of_buffer) begin
            o_phase      = PH_OUTER_TAG;
            o_len_left   = '0;
            o_value_left = '0;
            o_decided    = 1'b0;
        end
    end

endmodule

// File: sv/der_key_format_detector_top.sv
// ----------------------------------------------------------------------------
// DER key format detector
// Takes a DER encoded key one byte per request, the last byte flagged, and
// returns one format code per buffer: 0 unrecognised, 1 pkcs8, 2 spki,
// 3 encrypted pkcs8. The code is issued on the byte that settles the format,
// or on the last byte if nothing settled it earlier; bytes after a decision
// are consumed without a result. While ready, the block takes one byte every
// cycle: the parse state is updated in the cycle a byte is accepted, and the
// result request appears in the output register on the following cycle. Input
// ready drops only while a result is held in that register and the output side
// is not taking it. MAX_LENGTH_BYTES (1 to 8) sets the longest long-form
// length field accepted and the width of the inner length counter.
// ----------------------------------------------------------------------------
module der_key_format_detector_top #(
    parameter int MAX_LENGTH_BYTES = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_data_byte,
    input  logic              i_end_of_buffer,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output dkfd_pkg::t_format o_format
);
    import dkfd_pkg::*;

    localparam int LW = $clog2(MAX_LENGTH_BYTES + 1);
    localparam int VW = 8 * MAX_LENGTH_BYTES;

    t_phase        r_phase, n_phase;
    logic [LW-1:0] r_len_left, n_len_left;
    logic [VW-1:0] r_value_left, n_value_left;
    logic          r_decided, n_decided;
    logic          r_out_valid;
    t_format       r_format;
    t_result       step_result;
    logic          accept;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_format    = r_format;

    dkfd_step #(
        .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
    ) u_step (
        .i_phase        (r_phase),
        .i_len_left     (r_len_left),
        .i_value_left   (r_value_left),
        .i_decided      (r_decided),
        .i_data_byte    (i_data_byte),
        .i_end_of_buffer(i_end_of_buffer),
        .o_phase        (n_phase),
        .o_len_left     (n_len_left),
        .o_value_left   (n_value_left),
        .o_decided      (n_decided),
        .o_result       (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_OUTER_TAG;
            r_len_left   <= '0;
            r_value_left <= '0;
            r_decided    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_phase      <= n_phase;
                r_len_left   <= n_len_left;
                r_value_left <= n_value_left;
                r_decided    <= n_decided;
                r_out_valid  <= step_result.valid;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && step_result.valid) begin
            r_format <= step_result.format;
        end
    end

endmodule

// File: sv/dkfd_checker.sv
// ----------------------------------------------------------------------------
// DER key format detector port checker
// Watches the top level's handshakes and the result register over time.
// ----------------------------------------------------------------------------
module dkfd_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input dkfd_pkg::t_format o_format
);
    import dkfd_pkg::*;

    // A stalled result request keeps its value until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_format))
        else $error("result changed or dropped while stalled");

    // The input side is only held off by a waiting result.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input not ready without a stalled result");

    // Nothing comes out right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Every fresh result is caused by a byte accepted on the previous edge.
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !($past(o_out_valid) && !$past(i_out_ready)) && o_out_valid
        |-> $past(i_in_valid && o_in_ready))
        else $error("result without an accepted byte");

endmodule

bind der_key_format_detector_top dkfd_checker u_dkfd_checker (.*);
